### src/mandelbrot_escape_time_gray_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_GRAY_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_GRAY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define METG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define METG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/metg_pkg.sv
// ----------------------------------------------------------------------------
// metg_pkg
// Shared constants and types of the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package metg_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd6;

  // Image size registers are this wide.
  localparam int SIZE_W = 13;

  // Reset values of the configuration registers.
  localparam int RST_X_MIN    = -398226683;
  localparam int RST_X_MAX    = 551932825;
  localparam int RST_Y_MIN    = -471267971;
  localparam int RST_Y_MAX    = 478891538;
  localparam int RST_SIZE     = 500;
  localparam int RST_MAX_ITER = 1000;

  // Full-scale gray level.
  localparam logic [7:0] GRAY_MAX = 8'd255;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### src/metg_if.sv
// ----------------------------------------------------------------------------
// metg interfaces
// Valid/ready channels for configuration writes, pixels and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface metg_cfg_if #(
  parameter int DATA_W = 32
) ();
  logic                           valid;
  logic                           ready;
  logic [metg_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface metg_pix_if #(
  parameter int DIM_W = 12
) ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] column;
  logic [DIM_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface metg_res_if #(
  parameter int ITER_W = 16
) ();
  logic              valid;
  logic              ready;
  logic [7:0]        gray_level;
  logic [ITER_W-1:0] iteration_count;

  modport source (output valid, gray_level, iteration_count, input ready);
  modport sink   (input valid, gray_level, iteration_count, output ready);
endinterface

`default_nettype wire

### src/mandelbrot_escape_time_gray.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_gray
// Escape-time evaluator: maps a pixel to the complex plane, iterates
// z = z*z + c and returns the iteration count and a gray level.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i takes register writes (index, data) at any time the block is idle;
//   it is always ready. pix_i takes one pixel (column, row) per transaction,
//   res_o returns one (gray_level, iteration_count) per pixel, in order.
//   pix_i is ready only while no pixel is being evaluated.
// Sequence:
//   Mapping both coordinates takes two passes through a shared bit-serial
//   divider, and the gray level one more unless the limit is zero. Each
//   iteration goes through the product unit, then the escape test and
//   update; a new pixel is taken only once the last has left the sequencer.
// Reset:
//   rst_ni clears the sequencer and the output register and loads the
//   default view window, image size and iteration limit.
// Stalls:
//   A result waits in the output register while res_o.ready is low; a new
//   pixel may be taken meanwhile and waits for the register to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mandelbrot_escape_time_gray_assert.svh"

module mandelbrot_escape_time_gray #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 28,
  parameter int ITER_BITS  = 16,
  parameter int DIM_BITS   = 12
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  metg_cfg_if.sink   cfg_i,
  metg_pix_if.sink   pix_i,
  metg_res_if.source res_o
);

  localparam int Z_W    = FRAC_BITS + 12;
  localparam int X_W    = Z_W + 1;
  localparam int M_W    = FRAC_BITS + 3;
  localparam int P_W    = 2 * M_W;
  localparam int D_W    = COORD_BITS + 1;
  localparam int PR_W   = D_W + DIM_BITS + 1;
  localparam int MAG_W  = D_W + DIM_BITS;
  localparam int G_W    = ITER_BITS + 8;
  localparam int NUM_W  = (MAG_W > G_W) ? MAG_W : G_W;
  localparam int DEN_W  = (metg_pkg::SIZE_W > ITER_BITS) ? metg_pkg::SIZE_W : ITER_BITS;
  localparam int S_W    = (NUM_W + 2 > Z_W + 1) ? NUM_W + 2 : Z_W + 1;
  localparam int SQ_W   = P_W - FRAC_BITS;
  localparam int XY_W   = P_W - FRAC_BITS + 1;

  localparam logic signed [X_W-1:0] TWO =
    {{(X_W-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
  localparam logic signed [X_W-1:0] NEG_TWO = -TWO;
  localparam logic signed [SQ_W-1:0] FOUR =
    {3'b000, 1'b1, {(FRAC_BITS+2){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_DIV,
    S_MAP_WAIT,
    S_CHECK,
    S_SQUARE,
    S_GRAY_DIV,
    S_GRAY_WAIT,
    S_EMIT
  } state_e;

  // Configuration registers.
  logic signed [COORD_BITS-1:0]       x_min_q, x_max_q, y_min_q, y_max_q;
  logic        [metg_pkg::SIZE_W-1:0] width_q, height_q;
  logic        [ITER_BITS-1:0]        limit_q;

  // Sequencer and datapath registers.
  state_e                 state_q;
  logic                   axis_q;
  logic [DIM_BITS-1:0]    col_q, row_q;
  logic                   prod_neg_q;
  logic [MAG_W-1:0]       prod_mag_q;
  logic signed [Z_W-1:0]  cx_q, cy_q;
  logic signed [X_W-1:0]  x_q, y_q;
  logic [ITER_BITS-1:0]   count_q;
  logic [7:0]             gray_q;
  logic                   res_valid_q;
  logic [7:0]             res_gray_q;
  logic [ITER_BITS-1:0]   res_count_q;

  // Mapping datapath.
  logic signed [COORD_BITS-1:0]       lo, hi;
  logic        [DIM_BITS-1:0]         idx;
  logic        [metg_pkg::SIZE_W-1:0] size, size_eff;
  logic signed [D_W-1:0]              diff;
  logic signed [PR_W-1:0]             prod, prod_abs;
  logic signed [S_W-1:0]              quot_s, c_sum;
  logic        [S_W-Z_W:0]            c_top;
  logic signed [Z_W-1:0]              c_sat;

  // Divider connection.
  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [NUM_W-1:0]         div_quot;
  metg_pkg::div_stat_t      div_stat;
  logic [G_W-1:0]           gray_num;

  // Iteration datapath.
  logic                     mul_en;
  logic signed [P_W-1:0]    xx, yy, xy;
  logic signed [SQ_W-1:0]   xx_f, yy_f, mag_sum;
  logic signed [XY_W-1:0]   xy_f;
  logic                     outside;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= COORD_BITS'(metg_pkg::RST_X_MIN);
      x_max_q  <= COORD_BITS'(metg_pkg::RST_X_MAX);
      y_min_q  <= COORD_BITS'(metg_pkg::RST_Y_MIN);
      y_max_q  <= COORD_BITS'(metg_pkg::RST_Y_MAX);
      width_q  <= metg_pkg::SIZE_W'(metg_pkg::RST_SIZE);
      height_q <= metg_pkg::SIZE_W'(metg_pkg::RST_SIZE);
      limit_q  <= ITER_BITS'(metg_pkg::RST_MAX_ITER);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        metg_pkg::CFG_X_MIN:    x_min_q  <= cfg_i.data[COORD_BITS-1:0];
        metg_pkg::CFG_X_MAX:    x_max_q  <= cfg_i.data[COORD_BITS-1:0];
        metg_pkg::CFG_Y_MIN:    y_min_q  <= cfg_i.data[COORD_BITS-1:0];
        metg_pkg::CFG_Y_MAX:    y_max_q  <= cfg_i.data[COORD_BITS-1:0];
        metg_pkg::CFG_WIDTH:    width_q  <= cfg_i.data[metg_pkg::SIZE_W-1:0];
        metg_pkg::CFG_HEIGHT:   height_q <= cfg_i.data[metg_pkg::SIZE_W-1:0];
        metg_pkg::CFG_MAX_ITER: limit_q  <= cfg_i.data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Coordinate mapping: lo + idx*(hi-lo)/size, quotient truncated toward zero.
  assign lo       = axis_q ? y_min_q : x_min_q;
  assign hi       = axis_q ? y_max_q : x_max_q;
  assign idx      = axis_q ? row_q : col_q;
  assign size     = axis_q ? height_q : width_q;
  assign size_eff = (size == '0) ? metg_pkg::SIZE_W'(1) : size;
  assign diff     = D_W'(hi) - D_W'(lo);
  assign prod     = diff * $signed({1'b0, idx});
  assign prod_abs = prod[PR_W-1] ? -prod : prod;

  assign quot_s = prod_neg_q ? -S_W'(div_quot) : S_W'(div_quot);
  assign c_sum  = quot_s + S_W'(lo);
  assign c_top  = c_sum[S_W-1:Z_W-1];
  assign c_sat  = ((&c_top) || !(|c_top)) ? c_sum[Z_W-1:0] :
                  (c_sum[S_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}});

  // The shared divider serves both coordinates and the gray level.
  assign gray_num  = G_W'(count_q) * G_W'(metg_pkg::GRAY_MAX);
  assign div_start = (state_q == S_MAP_DIV) ||
                     ((state_q == S_GRAY_DIV) && (limit_q != '0));
  assign div_num   = (state_q == S_GRAY_DIV) ? NUM_W'(gray_num) : NUM_W'(prod_mag_q);
  assign div_den   = (state_q == S_GRAY_DIV) ? DEN_W'(limit_q) : DEN_W'(size_eff);

  metg_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Once |x| and |y| are within 2.0 the iterate fits the product operands.
  assign outside = (x_q > TWO) || (x_q < NEG_TWO) || (y_q > TWO) || (y_q < NEG_TWO);
  assign mul_en  = (state_q == S_CHECK);

  metg_mul_unit #(
    .M_W (M_W)
  ) u_mul_unit (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .x_i   (x_q[M_W-1:0]),
    .y_i   (y_q[M_W-1:0]),
    .xx_o  (xx),
    .yy_o  (yy),
    .xy_o  (xy)
  );

  // Dropping low bits of a two's complement product rounds toward minus infinity.
  assign xx_f    = xx[P_W-1:FRAC_BITS];
  assign yy_f    = yy[P_W-1:FRAC_BITS];
  assign xy_f    = xy[P_W-1:FRAC_BITS-1];
  assign mag_sum = xx_f + yy_f;

  assign pix_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = res_valid_q;
  assign res_o.gray_level      = res_gray_q;
  assign res_o.iteration_count = res_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      prod_neg_q  <= 1'b0;
      prod_mag_q  <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      count_q     <= '0;
      gray_q      <= '0;
      res_valid_q <= 1'b0;
      res_gray_q  <= '0;
      res_count_q <= '0;
    end else begin
      // In the emit state the output register is refilled or held below.
      if (res_valid_q && res_o.ready && (state_q != S_EMIT)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            col_q   <= pix_i.column;
            row_q   <= pix_i.row;
            axis_q  <= 1'b0;
            state_q <= S_MAP_MUL;
          end
        end
        S_MAP_MUL: begin
          prod_neg_q <= prod[PR_W-1];
          prod_mag_q <= prod_abs[MAG_W-1:0];
          state_q    <= S_MAP_DIV;
        end
        S_MAP_DIV: begin
          state_q <= S_MAP_WAIT;
        end
        S_MAP_WAIT: begin
          if (div_stat.done) begin
            if (!axis_q) begin
              cx_q    <= c_sat;
              axis_q  <= 1'b1;
              state_q <= S_MAP_MUL;
            end else begin
              cy_q    <= c_sat;
              x_q     <= X_W'(cx_q);
              y_q     <= X_W'(c_sat);
              count_q <= '0;
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!(count_q < limit_q) || outside) begin
            state_q <= S_GRAY_DIV;
          end else begin
            state_q <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mag_sum > FOUR) begin
            state_q <= S_GRAY_DIV;
          end else begin
            x_q     <= X_W'(xx_f) - X_W'(yy_f) + X_W'(cx_q);
            y_q     <= X_W'(xy_f) + X_W'(cy_q);
            count_q <= count_q + 1'b1;
            state_q <= S_CHECK;
          end
        end
        S_GRAY_DIV: begin
          if (limit_q == '0) begin
            gray_q  <= '0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_GRAY_WAIT;
          end
        end
        S_GRAY_WAIT: begin
          if (div_stat.done) begin
            gray_q  <= div_quot[7:0];
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_gray_q  <= gray_q;
            res_count_q <= count_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `METG_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, pix_i.valid && pix_i.ready, !pix_i.ready)
  `METG_ASSERT_NOW(a_div_start_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `METG_ASSERT_NOW(a_count_in_limit, clk_i, rst_ni, res_valid_q, res_count_q <= limit_q)
  `METG_ASSERT_NOW(a_full_gray, clk_i, rst_ni, res_valid_q && (res_count_q == limit_q) && (limit_q != '0), res_gray_q == metg_pkg::GRAY_MAX)

endmodule

`default_nettype wire

### src/metg_divider.sv
// ----------------------------------------------------------------------------
// metg_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module metg_divider #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NUM_W-1:0]    num_i,
  input  wire logic [DEN_W-1:0]    den_i,
  output metg_pkg::div_stat_t      stat_o,
  output logic      [NUM_W-1:0]    quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  // The remainder stays below the divisor, so one extra bit holds the trial.
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The numerator register shifts out dividend bits and takes in quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NUM_W-2:0], take};
      rem_q  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

### src/metg_mul_unit.sv
// ----------------------------------------------------------------------------
// metg_mul_unit
// Registered square and cross products of the iterate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module metg_mul_unit #(
  parameter int M_W = 31
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [M_W-1:0] x_i,
  input  wire logic signed [M_W-1:0] y_i,
  output logic signed [2*M_W-1:0]    xx_o,
  output logic signed [2*M_W-1:0]    yy_o,
  output logic signed [2*M_W-1:0]    xy_o
);

  logic signed [2*M_W-1:0] xx_q;
  logic signed [2*M_W-1:0] yy_q;
  logic signed [2*M_W-1:0] xy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= x_i * x_i;
      yy_q <= y_i * y_i;
      xy_q <= x_i * y_i;
    end
  end

  assign xx_o = xx_q;
  assign yy_o = yy_q;
  assign xy_o = xy_q;

endmodule

`default_nettype wire

### bench/metg_escape_checker.sv
// ----------------------------------------------------------------------------
// metg_escape_checker
// Watches the configuration, pixel and result channels of the escape-time
// evaluator. It keeps its own copy of the view window, image size and
// iteration limit, predicts the iteration count and gray level of every
// accepted pixel, and compares each result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module metg_escape_checker
  import metg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  metg_cfg_if         cfg,
  metg_pix_if         pix,
  metg_res_if         res,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int     FRAC_W   = 28;
  localparam int     Z_W      = FRAC_W + 12;
  localparam longint Z_TOP    = (64'sd1 <<< (Z_W - 1)) - 64'sd1;
  localparam longint Z_BOTTOM = -Z_TOP - 64'sd1;
  localparam longint TWO_Q    = 64'sd2 <<< FRAC_W;
  localparam longint FOUR_Q   = 64'sd4 <<< FRAC_W;

  typedef struct packed {
    logic [7:0]  gray_level;
    logic [15:0] iteration_count;
  } pixel_result_t;

  logic signed [31:0] re_lo, re_hi, im_lo, im_hi;
  logic [SIZE_W-1:0]  cols, rows;
  logic [15:0]        iter_limit;
  pixel_result_t      expected_pixels[$];
  int unsigned        fails, compared;

  // Maps a pixel index onto one axis. The quotient truncates toward zero and
  // the point is clamped to the range of the 40-bit iterate.
  function automatic longint plane_coord(logic signed [31:0] lo, logic signed [31:0] hi,
                                         logic [11:0] idx, logic [SIZE_W-1:0] size);
    longint divisor;
    longint c;
    divisor = (size == '0) ? 64'sd1 : longint'(size);
    c = longint'(lo) + (longint'(idx) * (longint'(hi) - longint'(lo))) / divisor;
    if (c > Z_TOP) c = Z_TOP;
    if (c < Z_BOTTOM) c = Z_BOTTOM;
    return c;
  endfunction

  // Either coordinate beyond 2.0 escapes before the squares are formed.
  function automatic bit is_bounded(longint x, longint y);
    longint ax, ay;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax > TWO_Q || ay > TWO_Q) return 1'b0;
    return ((x * x) >>> FRAC_W) + ((y * y) >>> FRAC_W) <= FOUR_Q;
  endfunction

  function automatic pixel_result_t escape_time(logic [11:0] col, logic [11:0] line);
    longint        cx, cy, x, y, x_next;
    longint        steps;
    pixel_result_t r;
    cx = plane_coord(re_lo, re_hi, col, cols);
    cy = plane_coord(im_lo, im_hi, line, rows);
    x = cx;
    y = cy;
    steps = 0;
    while (steps < longint'(iter_limit) && is_bounded(x, y)) begin
      x_next = ((x * x) >>> FRAC_W) - ((y * y) >>> FRAC_W) + cx;
      y = ((x * y) >>> (FRAC_W - 1)) + cy;
      x = x_next;
      steps++;
    end
    r.iteration_count = 16'(steps);
    if (iter_limit == '0) r.gray_level = '0;
    else r.gray_level = 8'((longint'(GRAY_MAX) * steps) / longint'(iter_limit));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      re_lo = RST_X_MIN;
      re_hi = RST_X_MAX;
      im_lo = RST_Y_MIN;
      im_hi = RST_Y_MAX;
      cols = SIZE_W'(RST_SIZE);
      rows = SIZE_W'(RST_SIZE);
      iter_limit = 16'(RST_MAX_ITER);
      expected_pixels.delete();
      fails = 0;
      compared = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_X_MIN:    re_lo = cfg.data;
          CFG_X_MAX:    re_hi = cfg.data;
          CFG_Y_MIN:    im_lo = cfg.data;
          CFG_Y_MAX:    im_hi = cfg.data;
          CFG_WIDTH:    cols = cfg.data[SIZE_W-1:0];
          CFG_HEIGHT:   rows = cfg.data[SIZE_W-1:0];
          CFG_MAX_ITER: iter_limit = cfg.data[15:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        expected_pixels.push_back(escape_time(pix.column, pix.row));
      end
      if (res.valid && res.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no pixel outstanding: gray_level %0d, iteration_count %0d",
                 res.gray_level, res.iteration_count);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          compared++;
          if (res.iteration_count !== want.iteration_count) begin
            $error("iteration_count: expected %0d, actual %0d",
                   want.iteration_count, res.iteration_count);
            fails++;
          end
          if (res.gray_level !== want.gray_level) begin
            $error("gray_level: expected %0d, actual %0d", want.gray_level, res.gray_level);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o <= expected_pixels.size();
      checked_o <= compared;
    end
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for the escape-time evaluator. A directed pass covers the reset
// view, zero image size and zero limit, clamped far-away points, reversed
// windows and the largest limit; random views, sizes and limits follow,
// with random gaps and stalls on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import metg_pkg::*;

  localparam int ITEM_TARGET = 600;
  localparam int Q_ONE       = 268435456;  // 1.0 in Q4.28

  logic        clk;
  logic        rst_n;
  bit          steady;
  int unsigned fail_count, pending, checked;
  int unsigned pixels_sent, settings_used, directed_count;
  int unsigned cur_width, cur_height;

  metg_cfg_if cfg_bus ();
  metg_pix_if pix_bus ();
  metg_res_if res_bus ();

  mandelbrot_escape_time_gray u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus.sink),
    .pix_i  (pix_bus.sink),
    .res_o  (res_bus.source)
  );

  metg_escape_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg          (cfg_bus),
    .pix          (pix_bus),
    .res          (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Drops the pixel request and waits until every result has come back, so
  // that register writes only land while the block is idle.
  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic settings_done();
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] line);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(7, 0);
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid  <= 1'b1;
    pix_bus.column <= col;
    pix_bus.row    <= line;
    do @(posedge clk); while (!pix_bus.ready);
    pixels_sent++;
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(9, 0))
      0: return 1;
      1: return 4096;
      2: return 0;
      default: return $urandom_range(64, 2);
    endcase
  endfunction

  function automatic logic [11:0] pick_index(int unsigned size);
    if (size == 0 || $urandom_range(7, 0) == 0) return 12'($urandom());
    return 12'($urandom_range(size - 1, 0));
  endfunction

  initial begin : result_sink
    int unsigned stall;
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(7, 0);
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  initial begin : stimulus
    logic [31:0]  x_lo, x_hi, y_lo, y_hi;
    logic [15:0]  limit;
    int unsigned  burst;
    rst_n = 1'b0;
    steady = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_X_MIN;
    cfg_bus.data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.column = '0;
    pix_bus.row = '0;
    pixels_sent = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset view and limit.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd250, 12'd250);
    send_pixel(12'd100, 12'd250);

    // Zero image size is taken as one; a zero limit gives no iterations.
    wait_idle();
    write_reg(CFG_WIDTH, 32'd0);
    write_reg(CFG_HEIGHT, 32'd0);
    write_reg(CFG_MAX_ITER, 32'd0);
    settings_done();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    wait_idle();
    write_reg(CFG_MAX_ITER, 32'd1);
    settings_done();
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd0, 12'd0);

    // Full-range window with a one-pixel image: far indexes get clamped.
    wait_idle();
    write_reg(CFG_X_MIN, 32'h8000_0000);
    write_reg(CFG_X_MAX, 32'h7FFF_FFFF);
    write_reg(CFG_Y_MIN, 32'h8000_0000);
    write_reg(CFG_Y_MAX, 32'h7FFF_FFFF);
    write_reg(CFG_WIDTH, 32'd1);
    write_reg(CFG_HEIGHT, 32'd1);
    write_reg(CFG_MAX_ITER, 32'd16);
    settings_done();
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1, 12'd1);

    // Reversed real axis clamps toward the negative end.
    wait_idle();
    write_reg(CFG_X_MIN, 32'h7FFF_FFFF);
    write_reg(CFG_X_MAX, 32'h8000_0000);
    settings_done();
    send_pixel(12'd4095, 12'd2048);

    // Largest image and limit; the origin runs the full limit.
    wait_idle();
    write_reg(CFG_X_MIN, -2 * Q_ONE);
    write_reg(CFG_X_MAX, 2 * Q_ONE);
    write_reg(CFG_Y_MIN, -2 * Q_ONE);
    write_reg(CFG_Y_MAX, 2 * Q_ONE);
    write_reg(CFG_WIDTH, 32'd4096);
    write_reg(CFG_HEIGHT, 32'd4096);
    write_reg(CFG_MAX_ITER, 32'd65535);
    settings_done();
    cur_width = 4096;
    cur_height = 4096;
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd3072, 12'd2048);
    send_pixel(12'd2600, 12'd2048);
    send_pixel(12'd4095, 12'd4095);
    directed_count = pixels_sent;

    // Random views: most near the set, some anywhere in the Q4.28 range.
    while (pixels_sent < directed_count + ITEM_TARGET) begin
      wait_idle();
      steady = ($urandom_range(3, 0) == 0);
      if ($urandom_range(4, 0) == 0) begin
        x_lo = $urandom();
        x_hi = $urandom();
        y_lo = $urandom();
        y_hi = $urandom();
      end else begin
        x_lo = -$urandom_range(5 * Q_ONE / 2, Q_ONE / 2);
        x_hi = $urandom_range(3 * Q_ONE / 2, 0) - Q_ONE / 4;
        y_lo = -$urandom_range(3 * Q_ONE / 2, 0);
        y_hi = $urandom_range(3 * Q_ONE / 2, 0);
      end
      case ($urandom_range(9, 0))
        0: limit = 16'd1;
        1: limit = 16'($urandom_range(256, 65));
        2: limit = 16'd0;
        default: limit = 16'($urandom_range(64, 2));
      endcase
      if ($urandom_range(3, 0) != 0) write_reg(CFG_X_MIN, x_lo);
      if ($urandom_range(3, 0) != 0) write_reg(CFG_X_MAX, x_hi);
      if ($urandom_range(3, 0) != 0) write_reg(CFG_Y_MIN, y_lo);
      if ($urandom_range(3, 0) != 0) write_reg(CFG_Y_MAX, y_hi);
      if ($urandom_range(3, 0) != 0) begin
        cur_width = pick_size();
        write_reg(CFG_WIDTH, 32'(cur_width));
      end
      if ($urandom_range(3, 0) != 0) begin
        cur_height = pick_size();
        write_reg(CFG_HEIGHT, 32'(cur_height));
      end
      // The limit is always rewritten so the large directed limit never lingers.
      write_reg(CFG_MAX_ITER, 32'(limit));
      settings_done();
      burst = $urandom_range(40, 10);
      repeat (burst) send_pixel(pick_index(cur_width), pick_index(cur_height));
    end

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Sent %0d pixels (%0d directed) under %0d register settings; %0d results compared.",
             pixels_sent, directed_count, settings_used, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("mandelbrot_escape_time_gray regression: pass");
    end else begin
      $display("mandelbrot_escape_time_gray regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("Run did not complete in time.");
    $display("mandelbrot_escape_time_gray regression: fail");
    $finish;
  end

endmodule
